@@ rtl/core/assert_macros.svh @@
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define CHK_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");
// next-cycle implication checked outside reset
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");
`endif

@@ rtl/core/pse_pkg.sv @@
// package: shared types and constants of the stroke extruder
`default_nettype none
package pse_pkg;
    localparam int CoordBits = 32;
    localparam int WidthBits = 31;
    localparam int DiffBits  = CoordBits + 1;
    localparam int MagBits   = CoordBits;
    localparam int SqBits    = 2 * DiffBits + 1;
    localparam int LenBits   = DiffBits + 1;
    localparam int ProdBits  = DiffBits + WidthBits;
    localparam logic [31:0] WidthReset = 32'd65536;
    localparam logic [1:0] AddrWidth = 2'd0;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SQ, ST_SQRT, ST_MULX, ST_DIVX, ST_MULY, ST_DIVY,
        ST_OUT0, ST_OUT1
    } t_state;

    typedef struct packed {
        logic load;      // latch chord differences and their magnitudes
        logic sq_start;
        logic sqrt_step;
        logic mulx;
        logic muly;
        logic div_start;
        logic div_step;
        logic divx_done;
    } t_cmd;

    typedef struct packed {
        logic sqrt_last;
        logic div_last;
        logic degen;
    } t_sts;
endpackage
`default_nettype wire

@@ rtl/core/pse_datapath.sv @@
// datapath: chord length by bitwise square root, offsets by restoring division
`default_nettype none
module pse_datapath (
    input  wire logic                             i_clk,
    input  wire pse_pkg::t_cmd                    i_cmd,
    input  wire logic signed [pse_pkg::DiffBits-1:0] i_dx,
    input  wire logic signed [pse_pkg::DiffBits-1:0] i_dy,
    input  wire logic [pse_pkg::WidthBits-1:0]    i_width,
    output pse_pkg::t_sts                         o_sts,
    output logic [pse_pkg::CoordBits-1:0]         o_ox,
    output logic [pse_pkg::CoordBits-1:0]         o_oy
);
    localparam int Lb = pse_pkg::LenBits;
    localparam int Sb = pse_pkg::SqBits;
    localparam int Pb = pse_pkg::ProdBits;
    localparam int Db = pse_pkg::DiffBits;

    logic signed [Db-1:0] r_dx, r_dy;
    logic [Db-1:0] r_ax, r_ay;
    logic [Sb:0]   r_sq;       // radicand, two bits consumed per step
    logic [Sb-1:0] n_rad;
    logic [Lb-1:0] r_len;      // sqrt result
    logic [Lb:0]   r_rem;      // sqrt remainder, at most twice the root
    logic [5:0]    r_cnt;
    logic [Pb-1:0] r_num;
    logic [Pb:0]   r_drem;
    logic [Pb-1:0] r_q;
    logic [Lb:0]   w_den;
    logic [Lb+3:0] w_trial;
    logic [Pb+1:0] w_dtrial;
    logic [Pb-1:0] w_qn;       // quotient including the bit of this step
    logic [Db-1:0] w_mx, w_my;

    assign w_mx = i_dx[Db-1] ? Db'(-i_dx) : Db'(i_dx);
    assign w_my = i_dy[Db-1] ? Db'(-i_dy) : Db'(i_dy);
    assign w_den = {r_len, 1'b0};
    // sqrt step: bring two radicand bits, trial 4*root+1
    assign w_trial = {1'b0, r_rem, r_sq[Sb -: 2]} - {2'b00, r_len, 2'b01};
    assign w_dtrial = {r_drem, r_num[Pb-1]} - (Pb+2)'(w_den);
    assign w_qn = {r_q[Pb-2:0], ~w_dtrial[Pb+1]};
    assign n_rad = Sb'(r_ax * r_ax) + Sb'(r_ay * r_ay);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_dx <= i_dx; r_dy <= i_dy; r_ax <= w_mx; r_ay <= w_my;
        end
        if (i_cmd.sq_start) begin
            r_sq <= {1'b0, n_rad}; // pad to even width
            r_rem <= '0; r_len <= '0; r_cnt <= 6'(Lb - 1);
        end else if (i_cmd.sqrt_step) begin
            r_sq <= {r_sq[Sb-2:0], 2'b00};
            r_cnt <= r_cnt - 6'd1;
            if (!w_trial[Lb+3]) begin
                r_rem <= w_trial[Lb:0]; r_len <= {r_len[Lb-2:0], 1'b1};
            end else begin
                r_rem <= {r_rem[Lb-2:0], r_sq[Sb -: 2]};
                r_len <= {r_len[Lb-2:0], 1'b0};
            end
        end else if (i_cmd.mulx || i_cmd.muly) begin
            r_num <= Pb'((i_cmd.mulx ? r_ay : r_ax) * i_width);
            r_drem <= '0; r_cnt <= 6'(Pb - 1);
        end else if (i_cmd.div_step) begin
            r_num <= {r_num[Pb-2:0], 1'b0};
            r_cnt <= r_cnt - 6'd1;
            if (!w_dtrial[Pb+1]) begin
                r_drem <= w_dtrial[Pb:0]; r_q <= {r_q[Pb-2:0], 1'b1};
            end else begin
                r_drem <= {r_drem[Pb-1:0], r_num[Pb-1]}; r_q <= {r_q[Pb-2:0], 1'b0};
            end
        end
        if (i_cmd.divx_done)
            o_ox <= (r_len == '0) ? '0 :
                (r_dy[Db-1] ? pse_pkg::CoordBits'(-r_q) : pse_pkg::CoordBits'(r_q));
        // taken on the last divide step, so the final quotient bit is included
        if (i_cmd.div_start)
            o_oy <= (r_len == '0) ? '0 :
                (r_dx[Db-1] ? pse_pkg::CoordBits'(-w_qn) : pse_pkg::CoordBits'(w_qn));
    end

    assign o_sts.sqrt_last = (r_cnt == '0);
    assign o_sts.div_last = (r_cnt == '0);
    assign o_sts.degen = (r_len == '0);
endmodule
`default_nettype wire

@@ rtl/core/pse_ctrl.sv @@
// controller: point buffer, sequencing of up to two vertex pairs per point
`default_nettype none
module pse_ctrl (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    output logic                           o_in_ready,
    input  wire logic [95:0]               i_in_data,
    input  wire logic                      i_in_last,
    output logic                           o_out_valid,
    input  wire logic                      i_out_ready,
    output logic [95:0]                    o_out_data,
    output logic [2:0]                     o_out_user,
    output pse_pkg::t_cmd                  o_cmd,
    input  wire pse_pkg::t_sts             i_sts,
    output logic signed [pse_pkg::DiffBits-1:0] o_dx,
    output logic signed [pse_pkg::DiffBits-1:0] o_dy,
    input  wire logic [31:0]               i_ox,
    input  wire logic [31:0]               i_oy
);
    pse_pkg::t_state r_state, n_state;
    logic [1:0]  r_seen;
    logic [31:0] r_p0x, r_p0y, r_p0z, r_p1x, r_p1y;       // newest, older
    logic [31:0] r_nx, r_ny, r_nz;                         // arriving point
    logic        r_second;           // second pair of a final point pending
    logic [31:0] r_vx, r_vy, r_vz;   // point of the current pair
    logic        r_fin, r_degen;
    logic        w_acc;

    assign o_in_ready = (r_state == pse_pkg::ST_IDLE);
    assign w_acc = i_in_valid && o_in_ready;
    assign o_out_valid = (r_state == pse_pkg::ST_OUT0) || (r_state == pse_pkg::ST_OUT1);

    // chord source selection
    always_comb begin
        logic [31:0] ax, ay, bx, by;
        if (r_second) begin
            ax = r_p0x; ay = r_p0y; bx = r_nx; by = r_ny;
        end else if (w_acc) begin
            ax = (r_seen >= 2'd2) ? r_p1x : r_p0x; ay = (r_seen >= 2'd2) ? r_p1y : r_p0y;
            bx = i_in_data[31:0]; by = i_in_data[63:32];
        end else begin
            ax = r_p0x; ay = r_p0y; bx = r_nx; by = r_ny;
        end
        o_dx = {ax[31], ax} - {bx[31], bx};
        o_dy = {ay[31], ay} - {by[31], by};
    end

    always_comb begin
        logic s;
        s = (r_state == pse_pkg::ST_OUT1);
        o_out_data[31:0]  = s ? r_vx + i_ox : r_vx - i_ox;
        o_out_data[63:32] = s ? r_vy - i_oy : r_vy + i_oy;
        o_out_data[95:64] = r_vz;
        o_out_user = {r_fin && s, r_degen, s};
    end

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        case (r_state)
            pse_pkg::ST_IDLE: begin
                if (w_acc && r_seen != 2'd0) begin
                    o_cmd.load = 1'b1; n_state = pse_pkg::ST_SQ;
                end
            end
            pse_pkg::ST_SQ: begin o_cmd.sq_start = 1'b1; n_state = pse_pkg::ST_SQRT; end
            pse_pkg::ST_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                if (i_sts.sqrt_last) n_state = pse_pkg::ST_MULX;
            end
            pse_pkg::ST_MULX: begin o_cmd.mulx = 1'b1; n_state = pse_pkg::ST_DIVX; end
            pse_pkg::ST_DIVX: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) n_state = pse_pkg::ST_MULY;
            end
            pse_pkg::ST_MULY: begin
                o_cmd.divx_done = 1'b1; o_cmd.muly = 1'b1; n_state = pse_pkg::ST_DIVY;
            end
            pse_pkg::ST_DIVY: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) n_state = pse_pkg::ST_OUT0;
            end
            pse_pkg::ST_OUT0: begin
                if (i_out_ready) n_state = pse_pkg::ST_OUT1;
            end
            pse_pkg::ST_OUT1: begin
                if (i_out_ready) begin
                    if (r_second) begin
                        o_cmd.load = 1'b1; n_state = pse_pkg::ST_SQ;
                    end else n_state = pse_pkg::ST_IDLE;
                end
            end
            default: n_state = pse_pkg::ST_IDLE;
        endcase
        // y offset latched on entry to the first output beat
        o_cmd.div_start = (r_state == pse_pkg::ST_DIVY) && i_sts.div_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pse_pkg::ST_IDLE;
            r_seen <= 2'd0;
            r_second <= 1'b0;
            r_p0x <= '0; r_p0y <= '0; r_p0z <= '0;
            r_p1x <= '0; r_p1y <= '0;
        end else begin
            r_state <= n_state;
            if (w_acc) begin
                r_nx <= i_in_data[31:0]; r_ny <= i_in_data[63:32]; r_nz <= i_in_data[95:64];
                r_vx <= r_p0x; r_vy <= r_p0y; r_vz <= r_p0z;
                r_fin <= !i_in_last;
                if (i_in_last) r_seen <= 2'd0;
                else begin
                    r_p1x <= r_p0x; r_p1y <= r_p0y;
                    r_p0x <= i_in_data[31:0]; r_p0y <= i_in_data[63:32];
                    r_p0z <= i_in_data[95:64];
                    r_seen <= (r_seen >= 2'd1) ? 2'd2 : 2'd1;
                end
                // second pair uses the old newest point against the final point
                r_second <= i_in_last && (r_seen != 2'd0);
            end else if (r_state == pse_pkg::ST_OUT1 && i_out_ready && r_second) begin
                r_second <= 1'b0;
                r_vx <= r_nx; r_vy <= r_ny; r_vz <= r_nz; r_fin <= 1'b1;
            end
            if (o_cmd.divx_done) r_degen <= i_sts.degen;
        end
    end
endmodule
`default_nettype wire

@@ rtl/core/polyline_stroke_extruder.sv @@
// top level: polyline stroke extruder with APB width register
// steps per pair: square, bit-serial sqrt, x multiply, x divide, y multiply, y divide;
//   the sqrt and two restoring divides share one datapath, and a final point runs the
//   sequence twice; a first point is only buffered and a lone point is dropped;
// otherwise ready drops until the last vertex is taken
// synchronous active-low reset clears control, point buffer and width (1.0)
`default_nettype none
module polyline_stroke_extruder (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [95:0] s_axis_tdata,  // point_x, point_y, point_z
    input  wire logic        s_axis_tlast,  // last_point
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [95:0]      m_axis_tdata,  // out_x, out_y, out_z
    output logic [2:0]       m_axis_tuser,  // side, degenerate, last_vertex
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    logic [30:0] r_width;
    pse_pkg::t_cmd w_cmd;
    pse_pkg::t_sts w_sts;
    logic signed [pse_pkg::DiffBits-1:0] w_dx, w_dy;
    logic [31:0] w_ox, w_oy;

    // apb register: stroke width
    assign pready = 1'b1;
    assign prdata = (paddr == pse_pkg::AddrWidth) ? {1'b0, r_width} : 32'd0;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_width <= pse_pkg::WidthReset[30:0];
        else if (psel && penable && pwrite && paddr == pse_pkg::AddrWidth)
            r_width <= pwdata[30:0];
    end

    pse_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .o_in_ready(s_axis_tready),
        .i_in_data(s_axis_tdata), .i_in_last(s_axis_tlast),
        .o_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .o_out_data(m_axis_tdata), .o_out_user(m_axis_tuser),
        .o_cmd(w_cmd), .i_sts(w_sts), .o_dx(w_dx), .o_dy(w_dy),
        .i_ox(w_ox), .i_oy(w_oy)
    );

    pse_datapath u_dp (
        .i_clk(i_clk), .i_cmd(w_cmd), .i_dx(w_dx), .i_dy(w_dy),
        .i_width(r_width), .o_sts(w_sts), .o_ox(w_ox), .o_oy(w_oy)
    );
endmodule
`default_nettype wire

@@ rtl/core/pse_checker.sv @@
// checker: port-level properties of the stroke extruder, bound to the top
`default_nettype none
`include "assert_macros.svh"
module pse_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       s_axis_tvalid,
    input wire logic       s_axis_tready,
    input wire logic       m_axis_tvalid,
    input wire logic       m_axis_tready,
    input wire logic [2:0] m_axis_tuser
);
    `CHK_IMPL(a_no_overlap, i_clk, i_rst_n, m_axis_tvalid, !s_axis_tready)
    `CHK_NEXT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    `CHK_IMPL(a_last_side, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser[2], m_axis_tuser[0])
    `CHK_NEXT(a_side_seq, i_clk, i_rst_n,
        m_axis_tvalid && m_axis_tready && !m_axis_tuser[0], m_axis_tvalid && m_axis_tuser[0])
endmodule
bind polyline_stroke_extruder pse_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tuser(m_axis_tuser)
);
`default_nettype wire

@@ tb/tb.sv @@
// testbench for the polyline stroke extruder: directed and random polylines
`timescale 1ns / 100ps
`default_nettype none
module tb;
    localparam int DRAIN_CYCLES = 400;   // covers one full pair computation and then some

    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic        side;
        logic        degen;
        logic        last_vtx;
    } t_vertex;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata;   // point_x, point_y, point_z
    logic        s_axis_tlast;   // last_point
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [95:0] m_axis_tdata;   // out_x, out_y, out_z
    logic [2:0]  m_axis_tuser;   // side, degenerate, last_vertex
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    polyline_stroke_extruder dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // predictor state: stroke width plus the two newest buffered points
    logic [30:0] width_q;
    logic [31:0] newest_x, newest_y, newest_z;
    logic [31:0] older_x, older_y;
    int          buffered;

    t_vertex expected_vertices[$];
    int      mismatches;
    int      src_idle_pct;
    int      snk_stall_pct;

    // clock, 2 ns period
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // hard stop in case the block hangs
    initial begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

    // receiver side: random backpressure, changed on the falling edge
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
    end

    // floor(sqrt(v)) bit by bit, 64-bit root
    function automatic logic [63:0] chord_len(input logic [127:0] v);
        logic [127:0] root;
        logic [127:0] trial;
        root = '0;
        for (int b = 63; b >= 0; b--) begin
            trial = root | (128'd1 << b);
            if (trial * trial <= v)
                root = trial;
        end
        return root[63:0];
    endfunction

    // trunc(comp * width / twice_len) with the sign of comp
    function automatic logic [63:0] offset_part(input longint comp,
                                                input logic [63:0] twice_len);
        logic [127:0] mag;
        logic [127:0] q;
        mag = (comp < 0) ? 128'(-comp) : 128'(comp);
        q = (mag * {97'd0, width_q}) / {64'd0, twice_len};
        return (comp < 0) ? -q[63:0] : q[63:0];
    endfunction

    // queue the two vertices of one point, chord (dx, dy)
    task automatic queue_pair(input logic [31:0] px, input logic [31:0] py,
                              input logic [31:0] pz, input longint dx, input longint dy,
                              input bit final_pair);
        logic [63:0] mx, my, len, ox, oy;
        logic [127:0] sumsq;
        t_vertex v;
        mx = (dx < 0) ? 64'(-dx) : 64'(dx);
        my = (dy < 0) ? 64'(-dy) : 64'(dy);
        sumsq = {64'd0, mx} * {64'd0, mx} + {64'd0, my} * {64'd0, my};
        len = chord_len(sumsq);
        ox = '0;
        oy = '0;
        if (len != 0) begin
            ox = offset_part(dy, len << 1);
            oy = offset_part(dx, len << 1);
        end
        for (int s = 0; s < 2; s++) begin
            v.x = (s == 0) ? px - ox[31:0] : px + ox[31:0];
            v.y = (s == 0) ? py + oy[31:0] : py - oy[31:0];
            v.z = pz;
            v.side = s[0];
            v.degen = (len == 0);
            v.last_vtx = final_pair && (s == 1);
            expected_vertices = {expected_vertices, v};
        end
    endtask

    // advance the point buffer for one accepted point
    task automatic predict_point(input logic [31:0] px, input logic [31:0] py,
                                 input logic [31:0] pz, input bit last);
        longint dx, dy;
        if (buffered != 0) begin
            // chord of the newest buffered point: its predecessor (or itself) minus p
            if (buffered >= 2) begin
                dx = longint'($signed(older_x)) - longint'($signed(px));
                dy = longint'($signed(older_y)) - longint'($signed(py));
            end else begin
                dx = longint'($signed(newest_x)) - longint'($signed(px));
                dy = longint'($signed(newest_y)) - longint'($signed(py));
            end
            queue_pair(newest_x, newest_y, newest_z, dx, dy, !last);
            if (last) begin
                dx = longint'($signed(newest_x)) - longint'($signed(px));
                dy = longint'($signed(newest_y)) - longint'($signed(py));
                queue_pair(px, py, pz, dx, dy, 1'b1);
            end
        end
        if (last) begin
            buffered = 0;
        end else begin
            older_x = newest_x;
            older_y = newest_y;
            newest_x = px;
            newest_y = py;
            newest_z = pz;
            buffered = (buffered >= 1) ? 2 : 1;
        end
    endtask

    // drive one point and wait for its transaction
    task automatic send_point(input logic [31:0] px, input logic [31:0] py,
                              input logic [31:0] pz, input bit last);
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {pz, py, px};
        s_axis_tlast <= last;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        predict_point(px, py, pz, last);
    endtask

    // wait until every queued vertex has come out, then let the block settle
    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (expected_vertices.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_width(input logic [30:0] w);
        @(negedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= pse_pkg::AddrWidth;
        pwdata <= {1'b0, w};
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        width_q = w;
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(3))
            0: return $urandom();                                  // full range
            1: return 32'($signed($urandom_range(2000)) - 1000) << 16;
            2: return 32'($urandom_range(65535)) - 32'd32768;
            default: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        endcase
    endfunction

    // result checker: each vertex transaction against the oldest expectation
    always @(posedge i_clk) begin
        t_vertex exp_v;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_vertices.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected vertex: data %h user %b", m_axis_tdata, m_axis_tuser);
            end else begin
                exp_v = expected_vertices.pop_front();
                if (m_axis_tdata !== {exp_v.z, exp_v.y, exp_v.x}
                        || m_axis_tuser !== {exp_v.last_vtx, exp_v.degen, exp_v.side}) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp x %h y %h z %h u %b, got x %h y %h z %h u %b",
                                 exp_v.x, exp_v.y, exp_v.z,
                                 {exp_v.last_vtx, exp_v.degen, exp_v.side},
                                 m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tdata[95:64],
                                 m_axis_tuser);
                end
            end
        end
    end

    // a lone point, short lines, zero chords, coordinate extremes and a longer line
    task automatic test_directed();
        send_point(32'h0001_0000, 32'h0002_0000, 32'h0000_0005, 1'b1);  // lone point
        send_point(32'h0000_0000, 32'h0000_0000, 32'h1111_1111, 1'b0);  // two-point line
        send_point(32'h0003_0000, 32'h0004_0000, 32'h2222_2222, 1'b1);
        send_point(32'h0005_0000, 32'h0005_0000, 32'h0, 1'b0);          // zero chords
        send_point(32'h0005_0000, 32'h0005_0000, 32'hFFFF_FFFF, 1'b0);
        send_point(32'h0005_0000, 32'h0005_0000, 32'h7FFF_FFFF, 1'b1);
        send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);  // extremes
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
        send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 1'b0);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1);
        send_point(32'hFFFF_0000, 32'h0001_0000, 32'h1, 1'b0);          // longer line
        send_point(32'h0000_8000, 32'hFFFF_8000, 32'h2, 1'b0);
        send_point(32'h0010_0000, 32'h0010_0000, 32'h3, 1'b0);
        send_point(32'h0010_0001, 32'h000F_FFFF, 32'h4, 1'b0);
        send_point(32'h0020_0000, 32'h0000_0000, 32'h5, 1'b1);
        drain();
    endtask

    // polylines of random length with random content
    task automatic test_random_lines(input int n_points);
        int sent;
        int run_len;
        logic [31:0] px, py;
        sent = 0;
        while (sent < n_points) begin
            run_len = ($urandom_range(9) == 0) ? 1 : $urandom_range(8, 2);
            for (int i = 0; i < run_len; i++) begin
                // repeat the point now and then to hit zero chords
                if (i == 0 || $urandom_range(7) != 0) begin
                    px = rand_coord();
                    py = rand_coord();
                end
                send_point(px, py, $urandom(), i == run_len - 1);
                sent++;
            end
        end
        drain();
    endtask

    task automatic test_width_settings();
        write_width(31'h7FFF_FFFF);
        test_random_lines(20);
        write_width(31'd0);
        test_random_lines(15);
        write_width(31'd1);
        test_random_lines(15);
    endtask

    initial begin
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        m_axis_tready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        width_q = pse_pkg::WidthReset[30:0];
        newest_x = '0;
        newest_y = '0;
        newest_z = '0;
        older_x = '0;
        older_y = '0;
        buffered = 0;
        mismatches = 0;
        src_idle_pct = 0;
        snk_stall_pct = 0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        write_width(31'h0003_0000);
        test_directed();

        test_width_settings();

        write_width(31'($urandom_range(32'h00FF_FFFF)));
        test_random_lines(60);
        src_idle_pct = 63;
        write_width(31'($urandom()));
        test_random_lines(60);
        src_idle_pct = 0;
        snk_stall_pct = 63;
        write_width(31'h0001_8000);
        test_random_lines(60);
        src_idle_pct = 37;
        snk_stall_pct = 37;
        write_width(31'($urandom_range(32'h0100_0000)));
        test_random_lines(60);

        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
`default_nettype wire
